// ===== src/sbds_pkg.sv =====
// sbds_pkg: shared types, constants and helper functions of the spi baud divider search
// used by every module and interface of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package sbds_pkg;

  // data widths of the fixed fields
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned PRESC_W  = 5;
  localparam int unsigned LOG2_W   = $clog2(DATA_W);
  localparam int unsigned ADDR_W   = 3;

  // default saturation point of the scaler code
  localparam int unsigned SCALER_CODE_MAX_DEF = 15;

  // module clock register reset value and register index
  localparam logic [DATA_W-1:0] CLK_HZ_RST = 32'd50000000;
  localparam logic              REG_CLK_HZ = 1'b0;

  // scaler codes whose divisor is not two to the power of the code
  localparam int unsigned SC_DIV2 = 0;
  localparam int unsigned SC_DIV4 = 1;
  localparam int unsigned SC_DIV6 = 2;

  // last prescaler index
  localparam logic [SEL_W-1:0] PRESC_LAST = 2'd3;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATIO_GO,
    ST_RATIO_WAIT,
    ST_CHECK,
    ST_QUOT_GO,
    ST_QUOT_WAIT,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // operand selection for the shared divider
  typedef enum logic [1:0] {
    OP_RATIO,
    OP_QUOT,
    OP_RATE
  } div_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load_target;
    logic             div_start;
    div_op_t          div_op;
    logic             cap_ratio;
    logic             cap_code;
    logic             cap_rate;
    logic             eval;
    logic [SEL_W-1:0] idx;
    logic             load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic ratio_small;
  } sts_t;

  // prescaler value for an index: 2, 3, 5, 7
  function automatic logic [PRESC_W-1:0] presc_val(input logic [SEL_W-1:0] idx);
    logic [PRESC_W-1:0] v;
    case (idx)
      2'd0:    v = 5'd2;
      2'd1:    v = 5'd3;
      2'd2:    v = 5'd5;
      default: v = 5'd7;
    endcase
    return v;
  endfunction

  // floor of log2 by leading one position, zero for zero
  function automatic logic [LOG2_W-1:0] log2_floor(input logic [DATA_W-1:0] q);
    logic [LOG2_W-1:0] lg;
    lg = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (q[i]) begin
        lg = LOG2_W'(i);
      end
    end
    return lg;
  endfunction

endpackage

`default_nettype wire

// ===== src/sbds_ifs.sv =====
// sbds_in_if and sbds_out_if: valid/ready channels of the spi baud divider search
// depends on sbds_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface sbds_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbds_pkg::DATA_W-1:0]  target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink   (input valid, input target_hz, output ready);
endinterface

interface sbds_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbds_pkg::SEL_W-1:0]   prescaler_sel;
  logic [sbds_pkg::CODE_W-1:0]  scaler_code;
  logic                         too_fast;

  modport source (output valid, output prescaler_sel, output scaler_code, output too_fast,
                  input ready);
  modport sink   (input valid, input prescaler_sel, input scaler_code, input too_fast,
                  output ready);
endinterface

`default_nettype wire

// ===== src/spi_baud_divider_search.sv =====
// spi_baud_divider_search: top level with the module clock register and apb-style port
// depends on sbds_pkg, sbds_ifs, sbds_ctrl and sbds_datapath
`timescale 1ns / 1ps
`default_nettype none

// For each requested SPI bit rate this block picks the baud prescaler (2, 3, 5 or 7)
// and the baud scaler code whose achieved rate from the configured module clock is
// closest to the request; ties go to the lower prescaler, and a clock-to-target ratio
// below two returns both codes as zero with too_fast set. A target of zero is taken as
// one. One request is processed at a time: it takes the request, then makes nine passes
// through one shared 32-bit divider that produces one quotient bit per cycle (the ratio,
// then a prescaled quotient and an achieved rate for each prescaler), with one ratio
// check after the ratio pass and one compare per prescaler, and then loads the result;
// when too_fast, only the ratio pass and check come before the result. A new request is
// taken while a finished result still waits for its transfer. The module clock register
// sits at byte address 0; the user must write it only while the block is idle, which
// the block itself does not enforce.
module spi_baud_divider_search #(
  parameter int unsigned SCALER_CODE_MAX = sbds_pkg::SCALER_CODE_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sbds_in_if.sink                          in_ch,
  sbds_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sbds_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sbds_pkg::DATA_W-1:0] pwdata,
  output logic [sbds_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  logic [sbds_pkg::DATA_W-1:0] clk_hz_r;
  logic                        reg_hit;
  sbds_pkg::cmd_t              cmd;
  sbds_pkg::sts_t              sts;

  // register decode on the word index
  assign reg_hit = (paddr[2] == sbds_pkg::REG_CLK_HZ);

  // module clock register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= sbds_pkg::CLK_HZ_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      clk_hz_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_hit ? clk_hz_r : '0;

  sbds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sbds_datapath #(
    .SCALER_CODE_MAX (SCALER_CODE_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .clk_hz            (clk_hz_r),
    .in_target_hz      (in_ch.target_hz),
    .out_prescaler_sel (out_ch.prescaler_sel),
    .out_scaler_code   (out_ch.scaler_code),
    .out_too_fast      (out_ch.too_fast)
  );

endmodule

`default_nettype wire

// ===== src/sbds_divider.sv =====
// sbds_divider: 32-bit unsigned restoring divider, one quotient bit per cycle
// depends on sbds_pkg for the data width
`timescale 1ns / 1ps
`default_nettype none

module sbds_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [sbds_pkg::DATA_W-1:0] dividend,
  input  wire logic [sbds_pkg::DATA_W-1:0] divisor,
  output logic                             done,
  output logic [sbds_pkg::DATA_W-1:0]      quotient
);

  localparam int unsigned W  = sbds_pkg::DATA_W;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  // one shift and trial subtract per cycle
  always_comb begin
    trial    = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[W]) begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
      end else begin
        rem_nxt = trial[W-1:0];
      end
      quo_nxt = {quo_r[W-2:0], ~trial[W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== src/sbds_datapath.sv =====
// sbds_datapath: ratio, per-prescaler scaler code, achieved rate and best-error tracking
// depends on sbds_pkg and sbds_divider
`timescale 1ns / 1ps
`default_nettype none

module sbds_datapath #(
  parameter int unsigned SCALER_CODE_MAX = sbds_pkg::SCALER_CODE_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sbds_pkg::cmd_t              cmd,
  output sbds_pkg::sts_t                   sts,
  input  wire logic [sbds_pkg::DATA_W-1:0] clk_hz,
  input  wire logic [sbds_pkg::DATA_W-1:0] in_target_hz,
  output logic [sbds_pkg::SEL_W-1:0]       out_prescaler_sel,
  output logic [sbds_pkg::CODE_W-1:0]      out_scaler_code,
  output logic                             out_too_fast
);

  localparam int unsigned W  = sbds_pkg::DATA_W;
  localparam int unsigned SW = sbds_pkg::SEL_W;
  localparam int unsigned PW = sbds_pkg::PRESC_W;
  localparam int unsigned LW = sbds_pkg::LOG2_W;
  localparam int unsigned CW = $clog2(SCALER_CODE_MAX + 1);

  logic [W-1:0]  target_r;
  logic [W-1:0]  ratio_r;
  logic [CW-1:0] code_r;
  logic [W-1:0]  rate_r;
  logic [W-1:0]  best_err_r;
  logic [SW-1:0] best_sel_r;
  logic [CW-1:0] best_code_r;
  logic [SW-1:0] out_sel_r;
  logic [CW-1:0] out_code_r;
  logic          out_tf_r;

  logic [W-1:0]  dvd, dvs, quo;
  logic          div_done;
  logic [PW-1:0] presc;
  logic [PW-1:0] rate_dvs;
  logic [LW-1:0] shamt;
  logic [LW-1:0] lg;
  logic [CW-1:0] code_new;
  logic [W-1:0]  err;

  assign presc = sbds_pkg::presc_val(cmd.idx);

  // clock shift and small divisor that give the achieved rate for the current code
  always_comb begin
    rate_dvs = presc;
    shamt    = LW'(code_r);
    if (code_r == CW'(sbds_pkg::SC_DIV2)) begin
      shamt = LW'(1);
    end else if (code_r == CW'(sbds_pkg::SC_DIV4)) begin
      shamt = LW'(2);
    end else if (code_r == CW'(sbds_pkg::SC_DIV6)) begin
      shamt    = LW'(1);
      rate_dvs = PW'(presc << 1) + presc;
    end
  end

  // divider operand selection
  always_comb begin
    case (cmd.div_op)
      sbds_pkg::OP_RATIO: begin
        dvd = clk_hz;
        dvs = target_r;
      end
      sbds_pkg::OP_QUOT: begin
        dvd = ratio_r;
        dvs = W'(presc);
      end
      default: begin
        dvd = clk_hz >> shamt;
        dvs = W'(rate_dvs);
      end
    endcase
  end

  sbds_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // scaler code from the prescaled quotient
  always_comb begin
    lg = sbds_pkg::log2_floor(quo);
    if (quo < W'(3)) begin
      code_new = CW'(sbds_pkg::SC_DIV2);
    end else if (quo < W'(7)) begin
      code_new = CW'(sbds_pkg::SC_DIV4);
    end else if (quo < W'(8)) begin
      code_new = CW'(sbds_pkg::SC_DIV6);
    end else if (lg > LW'(SCALER_CODE_MAX)) begin
      code_new = CW'(SCALER_CODE_MAX);
    end else begin
      code_new = CW'(lg);
    end
  end

  // absolute error of the achieved rate
  assign err = (rate_r > target_r) ? (rate_r - target_r) : (target_r - rate_r);

  // operand and candidate registers
  always_ff @(posedge clk) begin
    if (cmd.load_target) begin
      target_r <= (in_target_hz == '0) ? W'(1) : in_target_hz;
    end
    if (cmd.cap_ratio) begin
      ratio_r <= quo;
    end
    if (cmd.cap_code) begin
      code_r <= code_new;
    end
    if (cmd.cap_rate) begin
      rate_r <= quo;
    end
    // keep the first candidate, then only a strictly smaller error
    if (cmd.eval && ((cmd.idx == '0) || (err < best_err_r))) begin
      best_err_r  <= err;
      best_sel_r  <= cmd.idx;
      best_code_r <= code_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (sts.ratio_small) begin
        out_sel_r  <= '0;
        out_code_r <= '0;
        out_tf_r   <= 1'b1;
      end else begin
        out_sel_r  <= best_sel_r;
        out_code_r <= best_code_r;
        out_tf_r   <= 1'b0;
      end
    end
  end

  assign sts.div_done    = div_done;
  assign sts.ratio_small = (ratio_r[W-1:1] == '0);

  assign out_prescaler_sel = out_sel_r;
  assign out_scaler_code   = sbds_pkg::CODE_W'(out_code_r);
  assign out_too_fast      = out_tf_r;

endmodule

`default_nettype wire

// ===== src/sbds_ctrl.sv =====
// sbds_ctrl: sequencer of the baud divider search, drives the datapath and the handshakes
// depends on sbds_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbds_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sbds_pkg::cmd_t       cmd,
  input  wire sbds_pkg::sts_t  sts
);

  localparam int unsigned SW = sbds_pkg::SEL_W;

  sbds_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state, index and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbds_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.idx       = idx_r;
    cmd.div_op    = sbds_pkg::OP_RATIO;

    // result leaves on its transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      sbds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_target = 1'b1;
          state_nxt       = sbds_pkg::ST_RATIO_GO;
        end
      end
      sbds_pkg::ST_RATIO_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = sbds_pkg::ST_RATIO_WAIT;
      end
      sbds_pkg::ST_RATIO_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_ratio = 1'b1;
          state_nxt     = sbds_pkg::ST_CHECK;
        end
      end
      sbds_pkg::ST_CHECK: begin
        idx_nxt = '0;
        if (sts.ratio_small) begin
          state_nxt = sbds_pkg::ST_FINISH;
        end else begin
          state_nxt = sbds_pkg::ST_QUOT_GO;
        end
      end
      sbds_pkg::ST_QUOT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = sbds_pkg::OP_QUOT;
        state_nxt     = sbds_pkg::ST_QUOT_WAIT;
      end
      sbds_pkg::ST_QUOT_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_code = 1'b1;
          state_nxt    = sbds_pkg::ST_RATE_GO;
        end
      end
      sbds_pkg::ST_RATE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = sbds_pkg::OP_RATE;
        state_nxt     = sbds_pkg::ST_RATE_WAIT;
      end
      sbds_pkg::ST_RATE_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_rate = 1'b1;
          state_nxt    = sbds_pkg::ST_EVAL;
        end
      end
      sbds_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (idx_r == sbds_pkg::PRESC_LAST) begin
          state_nxt = sbds_pkg::ST_FINISH;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = sbds_pkg::ST_QUOT_GO;
        end
      end
      sbds_pkg::ST_FINISH: begin
        // load the result register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sbds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbds_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
